// ----- rtl/cdq_pkg.sv -----
package cdq_pkg;

   localparam int DEPTH   = 1024;
   localparam int INDEX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W   = $clog2(DEPTH + 1);
   localparam int CFG_W   = 11;
   localparam int CMP_W   = (CFG_W > CAP_W) ? CFG_W : CAP_W;
   localparam int DATA_W  = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;

   localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // pointer control to datapath: memory access and result flags of one transfer
   typedef struct packed {
      logic                     fire;
      logic                     ok;
      logic                     empty;
      logic                     full;
      logic                     wr_en;
      logic [INDEX_W-1:0]       wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic [INDEX_W-1:0]       rd_head;
      logic [INDEX_W-1:0]       rd_tail;
   } ctl_type;

endpackage

// ----- rtl/circular_deque_core.sv -----
// Channel   Ports                        Transfer when
// request   start, busy, req_data        start high and busy low at a rising edge
// response  rsp_valid, rsp_data          rsp_valid high at a rising edge, one result each
// config    csr_wdata, csr_we            csr_we high at a rising edge, queue empty, no request taken
//
// One request per cycle while busy is low; its response appears in the cycle
// after the transfer. The response is registered; its data comes from the
// registered read of the ring RAM at the updated head and tail (front, rear).
// Synchronous reset: queue empty, capacity DEPTH; busy stays high for the
// first cycle out of reset. RAM contents are not cleared.
// The response side cannot stall, so busy never rises after reset.
module circular_deque_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cdq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output cdq_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [cdq_pkg::CFG_W-1:0] csr_wdata
);

   cdq_pkg::ctl_type ctl;

   logic accept;
   logic busy_ff;
   logic rsp_valid_ff;
   logic ok_ff;
   logic empty_ff;
   logic full_ff;
   logic fwd_head_ff;
   logic fwd_tail_ff;
   logic signed [cdq_pkg::DATA_W-1:0] wdata_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rd_head_data;
   logic signed [cdq_pkg::DATA_W-1:0] rd_tail_data;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // head, tail, empty flag and capacity; decides the RAM write and reads
   cdq_ptr_ctl u_ptr_ctl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (ctl)
   );

   // ring store: one write port, read ports at the new head and new tail
   cdq_ring_ram u_ring_ram (
      .clock     (clock),
      .wr_en     (ctl.wr_en),
      .wr_addr   (ctl.wr_addr),
      .wr_data   (ctl.wr_data),
      .rd_addr_a (ctl.rd_head),
      .rd_addr_b (ctl.rd_tail),
      .rd_data_a (rd_head_data),
      .rd_data_b (rd_tail_data)
   );

   // Response control. The RAM reads old data when the pushed entry is read
   // in the same cycle, so remember a hit and forward the pushed value.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= ctl.fire;
      end
   end

   // payload: hold flags and forward data with the transfer
   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         ok_ff       <= ctl.ok;
         empty_ff    <= ctl.empty;
         full_ff     <= ctl.full;
         fwd_head_ff <= ctl.wr_en && (ctl.wr_addr == ctl.rd_head);
         fwd_tail_ff <= ctl.wr_en && (ctl.wr_addr == ctl.rd_tail);
         wdata_ff    <= ctl.wr_data;
      end
   end

   // drive response; an empty queue reports all-ones in both value fields
   always_comb begin
      rsp_data.ok       = ok_ff;
      rsp_data.is_empty = empty_ff;
      rsp_data.is_full  = full_ff;
      if (empty_ff) begin
         rsp_data.front_value = cdq_pkg::EMPTY_MARK;
         rsp_data.rear_value  = cdq_pkg::EMPTY_MARK;
      end else begin
         rsp_data.front_value = fwd_head_ff ? wdata_ff : rd_head_data;
         rsp_data.rear_value  = fwd_tail_ff ? wdata_ff : rd_tail_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // every transfer yields exactly one response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("request transfer without response");

   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without request transfer");

   // a rejected push means the queue was full and stays so
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok && ($past(req_data.op) == cdq_pkg::OP_PUSH_FRONT ||
       $past(req_data.op) == cdq_pkg::OP_PUSH_BACK)) |-> rsp_data.is_full)
      else $error("push rejected while queue not full");

   // a rejected pop means the queue was empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok && ($past(req_data.op) == cdq_pkg::OP_POP_FRONT ||
       $past(req_data.op) == cdq_pkg::OP_POP_BACK)) |-> rsp_data.is_empty)
      else $error("pop rejected while queue not empty");

endmodule

// ----- rtl/cdq_ring_ram.sv -----
module cdq_ring_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [cdq_pkg::INDEX_W-1:0]      wr_addr,
   input  logic signed [cdq_pkg::DATA_W-1:0] wr_data,
   input  logic [cdq_pkg::INDEX_W-1:0]      rd_addr_a,
   input  logic [cdq_pkg::INDEX_W-1:0]      rd_addr_b,
   output logic signed [cdq_pkg::DATA_W-1:0] rd_data_a,
   output logic signed [cdq_pkg::DATA_W-1:0] rd_data_b
);

   logic signed [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];
   logic signed [cdq_pkg::DATA_W-1:0] rd_data_a_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rd_data_b_ff;

   // read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/cdq_ptr_ctl.sv -----
module cdq_ptr_ctl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  cdq_pkg::req_type              req,
   input  logic                          csr_we,
   input  logic [cdq_pkg::CFG_W-1:0]     csr_wdata,
   output cdq_pkg::ctl_type              ctl
);

   logic [cdq_pkg::INDEX_W-1:0] head_ff, head_in;
   logic [cdq_pkg::INDEX_W-1:0] tail_ff, tail_in;
   logic                        empty_ff, empty_in;
   logic [cdq_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                        full_now;
   logic [cdq_pkg::CMP_W-1:0]   cfg_ext;

   function automatic logic [cdq_pkg::INDEX_W-1:0] idx_inc(
      input logic [cdq_pkg::INDEX_W-1:0] idx,
      input logic [cdq_pkg::CAP_W-1:0]   cap
   );
      logic [cdq_pkg::CAP_W-1:0] sum;
      sum = cdq_pkg::CAP_W'(idx) + cdq_pkg::CAP_W'(1);
      return (sum == cap) ? '0 : sum[cdq_pkg::INDEX_W-1:0];
   endfunction

   function automatic logic [cdq_pkg::INDEX_W-1:0] idx_dec(
      input logic [cdq_pkg::INDEX_W-1:0] idx,
      input logic [cdq_pkg::CAP_W-1:0]   cap
   );
      logic [cdq_pkg::CAP_W-1:0] last;
      last = cap - cdq_pkg::CAP_W'(1);
      return (idx == '0) ? last[cdq_pkg::INDEX_W-1:0] : idx - cdq_pkg::INDEX_W'(1);
   endfunction

   assign full_now = !empty_ff && (idx_inc(tail_ff, cap_ff) == head_ff);
   assign cfg_ext  = cdq_pkg::CMP_W'(csr_wdata);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      cap_in      = cap_ff;
      ctl.ok      = 1'b0;
      ctl.wr_en   = 1'b0;
      ctl.wr_addr = '0;
      ctl.wr_data = req.value;
      if (accept) begin
         unique case (req.op)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
               if (empty_ff) begin
                  head_in     = '0;
                  tail_in     = '0;
                  empty_in    = 1'b0;
                  ctl.wr_en   = 1'b1;
                  ctl.ok      = 1'b1;
               end else if (!full_now) begin
                  if (req.op == cdq_pkg::OP_PUSH_FRONT) begin
                     head_in     = idx_dec(head_ff, cap_ff);
                     ctl.wr_addr = head_in;
                  end else begin
                     tail_in     = idx_inc(tail_ff, cap_ff);
                     ctl.wr_addr = tail_in;
                  end
                  ctl.wr_en = 1'b1;
                  ctl.ok    = 1'b1;
               end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
               if (!empty_ff) begin
                  if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                  end else if (req.op == cdq_pkg::OP_POP_FRONT) begin
                     head_in = idx_inc(head_ff, cap_ff);
                  end else begin
                     tail_in = idx_dec(tail_ff, cap_ff);
                  end
                  ctl.ok = 1'b1;
               end
            end
            cdq_pkg::OP_QUERY: begin
               ctl.ok = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (csr_we && empty_ff) begin
         // clamp capacity into 1..DEPTH
         if (cfg_ext == '0) begin
            cap_in = cdq_pkg::CAP_W'(1);
         end else if (cfg_ext > cdq_pkg::CMP_W'(cdq_pkg::DEPTH)) begin
            cap_in = cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
         end else begin
            cap_in = cfg_ext[cdq_pkg::CAP_W-1:0];
         end
         head_in = '0;
         tail_in = '0;
      end
      ctl.fire    = accept;
      ctl.empty   = empty_in;
      ctl.full    = !empty_in && (idx_inc(tail_in, cap_ff) == head_in);
      ctl.rd_head = head_in;
      ctl.rd_tail = tail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         cap_ff   <= cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         cap_ff   <= cap_in;
      end
   end

endmodule
